// ----- src/pc_scan_code_translator_defines.svh -----
// Assertion macros shared by the scan code translator RTL.
`ifndef PC_SCAN_CODE_TRANSLATOR_DEFINES_SVH
`define PC_SCAN_CODE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pcsc_pkg.sv -----
// Types, key codes and default layout tables for the scan code translator.
`timescale 1ns / 1ps
package pcsc_pkg;

  localparam int CODES_PER_TABLE = 128;
  localparam int NUM_TABLES      = 5;
  localparam int MAP_ADDR_W      = $clog2(CODES_PER_TABLE);

  // table select codes
  localparam logic [2:0] TBL_PLAIN  = 3'd0;
  localparam logic [2:0] TBL_SHIFT  = 3'd1;
  localparam logic [2:0] TBL_ESCAPE = 3'd2;
  localparam logic [2:0] TBL_ALTGR  = 3'd3;
  localparam logic [2:0] TBL_CTRL   = 3'd4;

  // prefix bytes
  localparam logic [7:0] SCAN_ESCAPE = 8'hE0;
  localparam logic [7:0] SCAN_PAUSE  = 8'hE1;

  // key codes
  localparam logic [15:0] SPEC_MASK   = 16'hF800;
  localparam logic [15:0] FKEY_BASE   = 16'hF000;
  localparam logic [15:0] VIEW_KEY    = 16'hF800;
  localparam logic [15:0] SHIFT_KEY   = 16'hF860;
  localparam logic [15:0] BREAK_KEY   = 16'hF861;
  localparam logic [15:0] CTRL_KEY    = 16'hF862;
  localparam logic [15:0] LATIN_KEY   = 16'hF863;
  localparam logic [15:0] CAPS_KEY    = 16'hF864;
  localparam logic [15:0] NUM_KEY     = 16'hF865;
  localparam logic [15:0] ALTGR_KEY   = 16'hF867;
  localparam logic [15:0] GUI_KEY     = 16'hF868;
  localparam logic [15:0] SCROLL_KEY  = FKEY_BASE | 16'd21;
  localparam logic [15:0] MOUSE_FIRST = 16'hF901;
  localparam logic [15:0] MOUSE_LAST  = 16'hF905;
  localparam logic [15:0] DEL_KEY     = 16'h007F;
  localparam logic [15:0] LOWER_A     = 16'h0061;
  localparam logic [15:0] LOWER_Z     = 16'h007A;
  localparam logic [15:0] CASE_DELTA  = 16'h0020;
  localparam logic [15:0] CTRL_MASK   = 16'h001F;

  // modifier and lock bit positions
  localparam int MOD_SHIFT   = 0;
  localparam int MOD_CTRL    = 1;
  localparam int MOD_ALT     = 2;
  localparam int MOD_ALTGR   = 3;
  localparam int LOCK_CAPS   = 0;
  localparam int LOCK_NUM    = 1;
  localparam int LOCK_SCROLL = 2;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_LED     = 3'd2,
    KIND_MOUSE   = 3'd3,
    KIND_EXIT    = 3'd4,
    KIND_BAD_SEL = 3'd5
  } kind_t;

  // one map row holds the entry of every table for one scan code
  typedef logic [NUM_TABLES-1:0][15:0] map_row_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  scan_byte;
    logic [2:0]  table_select;
    logic [6:0]  table_index;
    logic [15:0] map_value;
  } item_t;

  typedef struct packed {
    logic       esc;
    logic [1:0] skip;
    logic [3:0] mods;
    logic [2:0] locks;
    logic [4:0] buttons;
  } kbd_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] char_code;
  } result_t;

  typedef struct packed {
    logic     en;
    map_row_t row;
  } map_wr_t;

  localparam logic [15:0] PLAIN_MAP [CODES_PER_TABLE] = '{
    16'h0000, 16'h001B, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
    16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h003D, 16'h0008, 16'h0009,
    16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
    16'h006F, 16'h0070, 16'h005B, 16'h005D, 16'h000A, CTRL_KEY, 16'h0061, 16'h0073,
    16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006A, 16'h006B, 16'h006C, 16'h003B,
    16'h0027, 16'h0060, SHIFT_KEY, 16'h005C, 16'h007A, 16'h0078, 16'h0063, 16'h0076,
    16'h0062, 16'h006E, 16'h006D, 16'h002C, 16'h002E, 16'h002F, SHIFT_KEY, 16'h002A,
    LATIN_KEY, 16'h0020, CTRL_KEY, 16'hF001, 16'hF002, 16'hF003, 16'hF004, 16'hF005,
    16'hF006, 16'hF007, 16'hF008, 16'hF009, 16'hF00A, NUM_KEY, 16'hF015, 16'h0037,
    16'h0038, 16'h0039, 16'h002D, 16'h0034, 16'h0035, 16'h0036, 16'h002B, 16'h0031,
    16'h0032, 16'h0033, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'hF00B,
    16'hF00C, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hF00D, 16'hF00E, 16'hF00F, 16'hF010,
    16'hF011, 16'hF012, 16'hF013, 16'hF014, 16'hF015, 16'hF016, 16'hF017, 16'hF018,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, VIEW_KEY, 16'h0000, 16'hF00E, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  localparam int SHIFT_LOW_N = 56;

  localparam logic [15:0] SHIFT_LOW_MAP [SHIFT_LOW_N] = '{
    16'h0000, 16'h001B, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005E,
    16'h0026, 16'h002A, 16'h0028, 16'h0029, 16'h005F, 16'h002B, 16'h0008, 16'h0009,
    16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
    16'h004F, 16'h0050, 16'h007B, 16'h007D, 16'h000A, CTRL_KEY, 16'h0041, 16'h0053,
    16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004A, 16'h004B, 16'h004C, 16'h003A,
    16'h0022, 16'h007E, SHIFT_KEY, 16'h007C, 16'h005A, 16'h0058, 16'h0043, 16'h0056,
    16'h0042, 16'h004E, 16'h004D, 16'h003C, 16'h003E, 16'h003F, SHIFT_KEY, 16'h002A
  };

  function automatic logic [15:0] esc_entry(logic [6:0] idx);
    logic [15:0] v;
    case (idx)
      7'h1C:   v = 16'h000A;
      7'h1D:   v = CTRL_KEY;
      7'h2A:   v = SHIFT_KEY;
      7'h35:   v = 16'h002F;
      7'h37:   v = 16'hF010;
      7'h38:   v = ALTGR_KEY;
      7'h46:   v = BREAK_KEY;
      7'h47:   v = 16'hF00D;
      7'h48:   v = 16'hF00E;
      7'h49:   v = 16'hF00F;
      7'h4B:   v = 16'hF011;
      7'h4D:   v = 16'hF012;
      7'h4F:   v = 16'hF018;
      7'h50:   v = VIEW_KEY;
      7'h51:   v = 16'hF013;
      7'h52:   v = 16'hF014;
      7'h53:   v = DEL_KEY;
      7'h5B:   v = GUI_KEY;
      7'h5C:   v = GUI_KEY;
      7'h79:   v = 16'hF00E;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // reset contents of one map row (all five tables at one scan code)
  function automatic map_row_t default_row(logic [6:0] idx);
    map_row_t    r;
    logic [15:0] p;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] c;
    p = PLAIN_MAP[idx];
    s = (idx < 7'h38) ? SHIFT_LOW_MAP[idx[5:0]] : p;
    if (idx == 7'h79) s = 16'hF00E;
    e = esc_entry(idx);
    c = p & CTRL_MASK;
    if (p == CTRL_KEY || p == SHIFT_KEY || p == LATIN_KEY) c = p;
    if (idx >= 7'h54 && idx <= 7'h56) c = 16'h0000;
    if (idx >= 7'h59) begin
      if (idx == 7'h79) c = 16'h000E;
      else if (idx == 7'h7B) c = 16'h0008;
      else c = 16'h0000;
    end
    r[TBL_PLAIN]  = p;
    r[TBL_SHIFT]  = s;
    r[TBL_ESCAPE] = e;
    r[TBL_ALTGR]  = (idx == 7'h5B || idx == 7'h5C) ? 16'h0000 : e;
    r[TBL_CTRL]   = c;
    return r;
  endfunction

endpackage

// ----- src/pcsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pcsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ----- src/pcsc_decode.sv -----
// Decode stage: picks the table entry, updates modifiers/locks/buttons, forms the result.
`timescale 1ns / 1ps
module pcsc_decode (
  input  pcsc_pkg::item_t      item,
  input  pcsc_pkg::map_row_t   row,
  input  pcsc_pkg::kbd_state_t st,
  output pcsc_pkg::kbd_state_t st_nxt,
  output pcsc_pkg::result_t    res,
  output pcsc_pkg::map_wr_t    wr
);
  import pcsc_pkg::*;

  logic [15:0] code_raw;
  logic [15:0] code;
  logic        keyup;
  logic        is_mouse;
  logic [2:0]  btn;

  // table priority: pending escape, then shift, altgr, ctrl, plain
  always_comb begin
    if (st.esc) code_raw = row[TBL_ESCAPE];
    else if (st.mods[MOD_SHIFT]) code_raw = row[TBL_SHIFT];
    else if (st.mods[MOD_ALTGR]) code_raw = row[TBL_ALTGR];
    else if (st.mods[MOD_CTRL]) code_raw = row[TBL_CTRL];
    else code_raw = row[TBL_PLAIN];
  end

  assign code     = (st.locks[LOCK_CAPS] && code_raw >= LOWER_A && code_raw <= LOWER_Z) ?
                    code_raw - CASE_DELTA : code_raw;
  assign keyup    = item.scan_byte[7];
  assign is_mouse = (code >= MOUSE_FIRST) && (code <= MOUSE_LAST);
  assign btn      = code[2:0] - 3'd1;

  always_comb begin
    st_nxt        = st;
    res.kind      = KIND_NONE;
    res.char_code = 16'h0000;
    wr.en         = 1'b0;
    wr.row        = row;
    if (item.action) begin
      if (item.table_select > TBL_CTRL) begin
        res.kind = KIND_BAD_SEL;
      end else begin
        wr.en                     = 1'b1;
        wr.row[item.table_select] = item.map_value;
      end
    end else if (item.scan_byte == SCAN_ESCAPE) begin
      st_nxt.esc = 1'b1;
    end else if (item.scan_byte == SCAN_PAUSE) begin
      st_nxt.skip = 2'd2;
    end else if (!st.esc && st.skip != 2'd0) begin
      st_nxt.skip = st.skip - 2'd1;
    end else begin
      st_nxt.esc = 1'b0;
      if (keyup) begin
        if (code == LATIN_KEY) st_nxt.mods[MOD_ALT] = 1'b0;
        else if (code == SHIFT_KEY) st_nxt.mods[MOD_SHIFT] = 1'b0;
        else if (code == CTRL_KEY) st_nxt.mods[MOD_CTRL] = 1'b0;
        else if (code == ALTGR_KEY) st_nxt.mods[MOD_ALTGR] = 1'b0;
        else if (is_mouse) begin
          st_nxt.buttons[btn] = 1'b0;
          res.kind            = KIND_MOUSE;
        end
      end else if ((code & SPEC_MASK) == 16'h0000) begin
        if (st.mods[MOD_CTRL] && st.mods[MOD_ALT] && code == DEL_KEY) begin
          res.kind = KIND_EXIT;
        end else begin
          res.kind      = KIND_CHAR;
          res.char_code = code;
        end
      end else begin
        case (code)
          CAPS_KEY: begin
            st_nxt.locks[LOCK_CAPS] = ~st.locks[LOCK_CAPS];
            res.kind                = KIND_LED;
          end
          SCROLL_KEY: begin
            st_nxt.locks[LOCK_SCROLL] = ~st.locks[LOCK_SCROLL];
            res.kind                  = KIND_LED;
          end
          NUM_KEY: begin
            st_nxt.locks[LOCK_NUM] = ~st.locks[LOCK_NUM];
            res.kind               = KIND_LED;
          end
          SHIFT_KEY: st_nxt.mods[MOD_SHIFT] = 1'b1;
          LATIN_KEY: st_nxt.mods[MOD_ALT]   = 1'b1;
          CTRL_KEY:  st_nxt.mods[MOD_CTRL]  = 1'b1;
          ALTGR_KEY: st_nxt.mods[MOD_ALTGR] = 1'b1;
          default: begin
            if (is_mouse) begin
              st_nxt.buttons[btn] = 1'b1;
              res.kind            = KIND_MOUSE;
            end else begin
              res.kind      = KIND_CHAR;
              res.char_code = code;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- src/pc_scan_code_translator.sv -----
// Top level of the set-1 scan code translator with writable key map.
//
//   channel  ports                                        direction  handshake
//   in       in_action/scan_byte/table_select/...         input      in_valid, in_stall
//   out      out_result_kind/char_code/*_on/button_mask  output     out_valid, out_stall
//
// One request per cycle sustained while out_stall is low. The map read is addressed
// straight from the input ports, so the row is registered on the accepting edge;
// the decode stage registers the result when it advances, and out_valid rises with it.
// The map is one 128 x 80 memory; each row holds a scan code's entry in all
// five tables, so the read address never depends on modifier state.
// Map writes read-modify-write their row; a write landing on the row being
// read in the same cycle is forwarded into the decode stage.
// After reset a sweep over all 128 map rows loads the default layout; in_stall is
// high throughout. A stalled output holds the decode stage, which stalls input.
`timescale 1ns / 1ps
`include "pc_scan_code_translator_defines.svh"
module pc_scan_code_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_scan_byte,
  input  logic [2:0]  in_table_select,
  input  logic [6:0]  in_table_index,
  input  logic [15:0] in_map_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [15:0] out_char_code,
  output logic        out_caps_on,
  output logic        out_num_on,
  output logic        out_scroll_on,
  output logic [4:0]  out_button_mask
);
  import pcsc_pkg::*;

  // init sweep
  logic                  init_r;
  logic [MAP_ADDR_W-1:0] init_cnt_r;

  // decode stage
  logic       b_valid_r;
  item_t      b_item_r;
  logic       fwd_hit_r;
  map_row_t   fwd_row_r;
  logic       b_go;
  logic       accept;
  item_t      in_item;

  kbd_state_t st_r;
  kbd_state_t st_nxt;
  result_t    res;
  map_wr_t    dec_wr;
  map_row_t   row_rd;
  map_row_t   row_use;

  // memory ports
  logic                  ram_we;
  logic [MAP_ADDR_W-1:0] ram_wa;
  map_row_t              ram_wd;
  logic [MAP_ADDR_W-1:0] ram_ra;

  logic out_valid_r;

  assign in_item.action       = in_action;
  assign in_item.scan_byte    = in_scan_byte;
  assign in_item.table_select = in_table_select;
  assign in_item.table_index  = in_table_index;
  assign in_item.map_value    = in_map_value;

  assign b_go     = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = init_r || (b_valid_r && !b_go);
  assign accept   = in_valid && !in_stall;

  // scan bytes address by their low seven bits, map writes by table_index
  assign ram_ra = in_action ? in_table_index : in_scan_byte[MAP_ADDR_W-1:0];

  always_comb begin
    if (init_r) begin
      ram_we = 1'b1;
      ram_wa = init_cnt_r;
      ram_wd = default_row(init_cnt_r);
    end else begin
      ram_we = b_go && dec_wr.en;
      ram_wa = b_item_r.table_index;
      ram_wd = dec_wr.row;
    end
  end

  pcsc_ram #(
    .WIDTH ($bits(map_row_t)),
    .DEPTH (CODES_PER_TABLE)
  ) u_map_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (accept),
    .ra  (ram_ra),
    .rd  (row_rd)
  );

  // a write committing on the edge of our read is not in the read data yet
  assign row_use = fwd_hit_r ? fwd_row_r : row_rd;

  pcsc_decode u_decode (
    .item   (b_item_r),
    .row    (row_use),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res),
    .wr     (dec_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      init_cnt_r  <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (init_r) begin
        init_cnt_r <= init_cnt_r + 1'b1;
        if (init_cnt_r == MAP_ADDR_W'(CODES_PER_TABLE - 1)) begin
          init_r <= 1'b0;
        end
      end
      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_go) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r  <= in_item;
      fwd_hit_r <= ram_we && (ram_wa == ram_ra);
      fwd_row_r <= ram_wd;
    end
    if (b_go) begin
      out_result_kind <= res.kind;
      out_char_code   <= res.char_code;
      out_caps_on     <= st_nxt.locks[LOCK_CAPS];
      out_num_on      <= st_nxt.locks[LOCK_NUM];
      out_scroll_on   <= st_nxt.locks[LOCK_SCROLL];
      out_button_mask <= st_nxt.buttons;
    end
  end

  assign out_valid = out_valid_r;

  `PCSC_ASSERT_NOW(a_no_item_in_init, init_r, !b_valid_r, "request in flight during map init")
  `PCSC_ASSERT_NOW(a_bad_sel_no_write,
    b_go && b_item_r.action && b_item_r.table_select > TBL_CTRL, !ram_we,
    "bad table select wrote the map")
  `PCSC_ASSERT_NEXT(a_char_zero,
    b_go && res.kind != KIND_CHAR, out_char_code == 16'h0000,
    "char_code nonzero for non-character result")

endmodule
